// ===== design/text_console_writer_assert.svh =====
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw: same-cycle check failed");

`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw: next-cycle check failed");

`else

`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // word index of text_attribute, taken from paddr[2]
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_LF       = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'd126;
    localparam logic [CHAR_W-1:0] CHAR_BLANK    = 8'h20;

    localparam int TAB_STEP = 4;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CHAR_BLANK};

    localparam logic [IDX_W-1:0] COPY_END  = IDX_W'(CELL_COUNT - COLUMNS);
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELL_COUNT - 1);

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] character;
        logic [IDX_W-1:0]  cell_index;
    } tcw_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic [CELL_W-1:0] cell_value;
    } tcw_out_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_GLYPH,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_TAB,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] glyph;
        logic [IDX_W-1:0]  cell_index;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q2b_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } b2q_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_COPY,
        BK_FILL
    } bk_state_t;

endpackage

`default_nettype wire

// ===== design/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/tcw_front.sv =====
`default_nettype none

module tcw_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire tcw_pkg::tcw_in_t item,
    output tcw_pkg::q2b_t         q2b,
    input  wire tcw_pkg::b2q_t    b2q
);

    import tcw_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t            cmd_in;
    cmd_t            q_mem_reg [CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            take;

    always_comb
    begin
        cmd_in.glyph      = item.character;
        cmd_in.cell_index = item.cell_index;
        unique case (item.operation)
            OP_PUT:
            begin
                priority if (item.character == CHAR_LF)
                    cmd_in.kind = CMD_NEWLINE;
                else if (item.character == CHAR_CR)
                    cmd_in.kind = CMD_RETURN;
                else if (item.character == CHAR_TAB)
                    cmd_in.kind = CMD_TAB;
                else if (item.character >= CHAR_PRINT_LO && item.character <= CHAR_PRINT_HI)
                    cmd_in.kind = CMD_GLYPH;
                else
                    cmd_in.kind = CMD_NOP;
            end
            OP_CLEAR: cmd_in.kind = CMD_CLEAR;
            OP_READ:  cmd_in.kind = (item.cell_index < IDX_W'(CELL_COUNT)) ? CMD_READ : CMD_NOP;
            default:  cmd_in.kind = CMD_NOP;
        endcase
    end

    assign full = (cnt_reg == CW'(CMDQ_DEPTH)) || b2q.init_busy;
    assign take = push && !full;

    assign q2b.valid = (cnt_reg != '0);
    assign q2b.cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = take    ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = b2q.pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(take) - CW'(b2q.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/tcw_back.sv =====
`default_nettype none

module tcw_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tcw_pkg::q2b_t               q2b,
    output tcw_pkg::b2q_t                    b2q,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  attr,
    output logic                             empty,
    input  wire logic                        pop,
    output tcw_pkg::tcw_out_t                result
);

    import tcw_pkg::*;

    localparam int RPW = $clog2(RESQ_DEPTH);
    localparam int RCW = $clog2(RESQ_DEPTH + 1);

    bk_state_t         state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  wa_reg, wa_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_wa;
    logic [CELL_W-1:0] ram_wd;
    logic [IDX_W-1:0]  ram_ra;
    logic [CELL_W-1:0] ram_rd;

    tcw_out_t          res_mem_reg [RESQ_DEPTH];
    logic [RPW-1:0]    res_wr_reg, res_rd_reg;
    logic [RCW-1:0]    res_cnt_reg;
    logic              res_push;
    logic              res_pop;
    tcw_out_t          res_word;

    logic              start;
    cmd_kind_t         kind;
    logic [COL_W-1:0]  col_sum;
    logic [ROW_W-1:0]  step_row;
    logic [COL_W-1:0]  step_col;
    logic              step_scroll;
    logic [IDX_W-1:0]  glyph_addr;

    assign kind  = q2b.cmd.kind;
    assign start = (state_reg == BK_IDLE) && q2b.valid && (res_cnt_reg != RCW'(RESQ_DEPTH));

    assign col_sum    = col_reg + ((kind == CMD_TAB) ? COL_W'(TAB_STEP) : COL_W'(1));
    assign glyph_addr = IDX_W'(IDX_W'(row_reg) * IDX_W'(COLUMNS)) + IDX_W'(col_reg);

    // cursor after one teletype step; scroll when stepping off the bottom row
    always_comb
    begin
        step_row    = row_reg;
        step_col    = col_reg;
        step_scroll = 1'b0;
        unique case (kind)
            CMD_GLYPH, CMD_TAB:
            begin
                if (col_sum >= COL_W'(COLUMNS))
                begin
                    step_col = '0;
                    if (row_reg == ROW_W'(ROWS - 1))
                        step_scroll = 1'b1;
                    else
                        step_row = row_reg + ROW_W'(1);
                end
                else
                begin
                    step_col = col_sum;
                end
            end
            CMD_NEWLINE:
            begin
                step_col = '0;
                if (row_reg == ROW_W'(ROWS - 1))
                    step_scroll = 1'b1;
                else
                    step_row = row_reg + ROW_W'(1);
            end
            CMD_RETURN:
            begin
                step_col = '0;
            end
            CMD_CLEAR:
            begin
                step_row = '0;
                step_col = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT:
            begin
                if (ptr_reg == LAST_CELL)
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (start)
                begin
                    priority if (kind == CMD_READ)
                        state_next = BK_READ;
                    else if (kind == CMD_CLEAR)
                        state_next = BK_FILL;
                    else if (step_scroll)
                        state_next = BK_COPY;
                    else
                        state_next = BK_IDLE;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            BK_COPY:
            begin
                if (ptr_reg == COPY_END)
                    state_next = BK_FILL;
            end
            BK_FILL:
            begin
                if (ptr_reg == LAST_CELL)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_INIT;
            end
        endcase
    end

    always_comb
    begin
        ptr_next  = ptr_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        pend_next = 1'b0;
        wa_next   = wa_reg;
        ram_we    = 1'b0;
        ram_wa    = '0;
        ram_wd    = '0;
        ram_ra    = '0;
        b2q.pop   = 1'b0;
        b2q.init_busy = (state_reg == BK_INIT);
        res_push  = 1'b0;
        res_word.cursor_row    = row_reg;
        res_word.cursor_column = col_reg;
        res_word.cell_value    = '0;
        unique case (state_reg)
            BK_INIT:
            begin
                ram_we   = 1'b1;
                ram_wa   = ptr_reg;
                ram_wd   = RESET_CELL;
                ptr_next = (ptr_reg == LAST_CELL) ? '0 : ptr_reg + IDX_W'(1);
            end
            BK_IDLE:
            begin
                if (start)
                begin
                    b2q.pop  = 1'b1;
                    row_next = step_row;
                    col_next = step_col;
                    res_word.cursor_row    = step_row;
                    res_word.cursor_column = step_col;
                    if (kind == CMD_GLYPH)
                    begin
                        ram_we = 1'b1;
                        ram_wa = glyph_addr;
                        ram_wd = {attr, q2b.cmd.glyph};
                    end
                    if (kind == CMD_READ)
                        ram_ra = q2b.cmd.cell_index;
                    if (kind == CMD_CLEAR || step_scroll)
                        ptr_next = '0;
                    res_push = (kind != CMD_READ) && (kind != CMD_CLEAR) && !step_scroll;
                end
            end
            BK_READ:
            begin
                res_push            = 1'b1;
                res_word.cell_value = ram_rd;
            end
            BK_COPY:
            begin
                // read one row ahead, write it back in the next cycle
                ram_we = pend_reg;
                ram_wa = wa_reg;
                ram_wd = ram_rd;
                if (ptr_reg != COPY_END)
                begin
                    ram_ra    = ptr_reg + IDX_W'(COLUMNS);
                    pend_next = 1'b1;
                    wa_next   = ptr_reg;
                    ptr_next  = ptr_reg + IDX_W'(1);
                end
            end
            BK_FILL:
            begin
                ram_we = 1'b1;
                ram_wa = ptr_reg;
                ram_wd = {attr, CHAR_BLANK};
                if (ptr_reg == LAST_CELL)
                begin
                    res_push = 1'b1;
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    assign empty   = (res_cnt_reg == '0);
    assign res_pop = pop && !empty;
    assign result  = res_mem_reg[res_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_INIT;
            ptr_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            pend_reg    <= 1'b0;
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pend_reg    <= pend_next;
            res_wr_reg  <= res_push ? res_wr_reg + RPW'(1) : res_wr_reg;
            res_rd_reg  <= res_pop ? res_rd_reg + RPW'(1) : res_rd_reg;
            res_cnt_reg <= res_cnt_reg + RCW'(res_push) - RCW'(res_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg <= wa_next;
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/text_console_writer.sv =====
// Teletype text console over an 80x25 screen of 16-bit cells (attribute byte
// high, character low). Words go in through a 2-deep command queue and come
// out through a 2-deep result queue, one result per word. Printable
// characters, newline, return, tab and reads of out-of-range cells are
// executed in the cycle they leave the command queue; an in-range read goes
// on to BK_READ for the registered RAM read. A step off the bottom row
// scrolls: the screen RAM (one read and one write port) is walked for the
// row copy in BK_COPY and then over the blank last row in BK_FILL. Clear
// writes every cell in BK_FILL. After reset the screen is blanked by a pass
// over every cell in BK_INIT during which full stays high; register writes
// are taken throughout. text_attribute sits at byte address 0.
`default_nettype none

`include "text_console_writer_assert.svh"

module text_console_writer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire tcw_pkg::tcw_in_t            item,
    output logic                             empty,
    input  wire logic                        pop,
    output tcw_pkg::tcw_out_t                result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcw_pkg::APB_AW-1:0]  paddr,
    input  wire logic [tcw_pkg::APB_DW-1:0]  pwdata,
    output logic      [tcw_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              attr_sel;
    q2b_t              q2b;
    b2q_t              b2q;
    logic              cursor_ok;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[2] == REG_TEXT_ATTRIBUTE);

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready && attr_sel)
            attr_next = pwdata[ATTR_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (attr_sel)
            prdata = {{(APB_DW - ATTR_W){1'b0}}, attr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= RESET_ATTR;
        else
            attr_reg <= attr_next;
    end

    tcw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .q2b   (q2b),
        .b2q   (b2q)
    );

    tcw_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q2b    (q2b),
        .b2q    (b2q),
        .attr   (attr_reg),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    assign cursor_ok = (result.cursor_row < ROW_W'(ROWS)) &&
                       (result.cursor_column < COL_W'(COLUMNS));

    `TCW_ASSERT_NOW(a_init_blocks_input, clk, rst_n, b2q.init_busy, full)
    `TCW_ASSERT_NEXT(a_accept_queues, clk, rst_n, push && !full, q2b.valid)
    `TCW_ASSERT_NOW(a_pop_has_word, clk, rst_n, b2q.pop, q2b.valid)
    `TCW_ASSERT_NOW(a_cursor_on_screen, clk, rst_n, !empty, cursor_ok)

endmodule

`default_nettype wire

// ===== dv/text_console_writer_test.sv =====
`default_nettype none

module text_console_writer_test;

    import tcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 420;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        reps;
        logic              typed;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_exp;
    } step_row_t;

    typedef struct packed {
        logic     typed;
        tcw_out_t value;
    } typed_result_t;

    localparam int N_STEPS = 21;

    // typed rows carry the cursor and cell straight from the spec
    localparam step_row_t STEPS [N_STEPS] = '{
        '{OP_READ,   8'hFF,         11'd0,    8'd1,  1'b1, 5'd0, 7'd0, RESET_CELL},
        '{OP_READ,   8'h00,         11'd1999, 8'd1,  1'b1, 5'd0, 7'd0, RESET_CELL},
        '{OP_READ,   8'hA5,         11'h7FF,  8'd1,  1'b1, 5'd0, 7'd0, 16'h0000},
        '{OP_UNUSED, 8'hFF,         11'h7FF,  8'd1,  1'b1, 5'd0, 7'd0, 16'h0000},
        '{OP_CLEAR,  8'hAA,         11'h555,  8'd1,  1'b1, 5'd0, 7'd0, 16'h0000},
        '{OP_PUT,    8'h41,         11'h7FF,  8'd1,  1'b1, 5'd0, 7'd1, 16'h0000},
        '{OP_PUT,    CHAR_PRINT_HI, 11'h2AA,  8'd1,  1'b1, 5'd0, 7'd2, 16'h0000},
        '{OP_PUT,    CHAR_PRINT_LO, 11'h000,  8'd1,  1'b1, 5'd0, 7'd3, 16'h0000},
        '{OP_PUT,    8'h7F,         11'h7FF,  8'd1,  1'b1, 5'd0, 7'd3, 16'h0000},
        '{OP_PUT,    8'hFF,         11'h7FF,  8'd1,  1'b1, 5'd0, 7'd3, 16'h0000},
        '{OP_PUT,    8'h00,         11'h000,  8'd1,  1'b1, 5'd0, 7'd3, 16'h0000},
        '{OP_PUT,    8'h1F,         11'h3FF,  8'd1,  1'b1, 5'd0, 7'd3, 16'h0000},
        '{OP_READ,   8'h00,         11'd0,    8'd1,  1'b1, 5'd0, 7'd3, {RESET_ATTR, 8'h41}},
        '{OP_READ,   8'h55,         11'd1,    8'd1,  1'b1, 5'd0, 7'd3, {RESET_ATTR, 8'h7E}},
        '{OP_PUT,    CHAR_TAB,      11'h7FF,  8'd1,  1'b1, 5'd0, 7'd7, 16'h0000},
        '{OP_PUT,    CHAR_CR,       11'h7FF,  8'd1,  1'b1, 5'd0, 7'd0, 16'h0000},
        '{OP_PUT,    CHAR_LF,       11'h000,  8'd1,  1'b1, 5'd1, 7'd0, 16'h0000},
        '{OP_PUT,    CHAR_TAB,      11'h000,  8'd19, 1'b0, 5'd0, 7'd0, 16'h0000},
        '{OP_PUT,    CHAR_TAB,      11'h7FF,  8'd1,  1'b1, 5'd2, 7'd0, 16'h0000},
        '{OP_PUT,    8'h5A,         11'h7FF,  8'd1,  1'b0, 5'd0, 7'd0, 16'h0000},
        '{OP_READ,   8'hFF,         11'd160,  8'd1,  1'b1, 5'd2, 7'd1, {RESET_ATTR, 8'h5A}}
    };

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                push    = 1'b0;
    logic                full;
    tcw_in_t             item    = '0;
    logic                empty;
    logic                pop     = 1'b0;
    tcw_out_t            result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    text_console_writer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the screen and cursor
    logic [CELL_W-1:0] screen_copy [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] attr_now;

    tcw_out_t      awaited_q [$];
    typed_result_t typed_q [$];

    int send_idle;
    int recv_idle;
    bit hold_wanted;
    int hold_count;
    int quiet_cycles;
    int mismatches;
    int n_words;
    int n_scrolls;
    int n_clears;
    int n_reads_oob;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s expected %0h got %0h", what, want, got);
    endtask

    task automatic console_step(input tcw_in_t w, output tcw_out_t r);
        int idx;
        logic [CELL_W-1:0] rd_word;
        rd_word = '0;
        case (w.operation)
            OP_PUT:
            begin
                if (w.character == CHAR_LF)
                begin
                    cur_row++;
                    cur_col = 0;
                end
                else if (w.character == CHAR_CR)
                    cur_col = 0;
                else if (w.character == CHAR_TAB)
                    cur_col += TAB_STEP;
                else if (w.character >= CHAR_PRINT_LO && w.character <= CHAR_PRINT_HI)
                begin
                    idx = cur_row * COLUMNS + cur_col;
                    if (idx < CELL_COUNT)
                        screen_copy[idx] = {attr_now, w.character};
                    cur_col++;
                end
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_copy[i] = screen_copy[i + COLUMNS];
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_copy[i] = {attr_now, CHAR_BLANK};
                    cur_row = ROWS - 1;
                    n_scrolls++;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_copy[i] = {attr_now, CHAR_BLANK};
                cur_row = 0;
                cur_col = 0;
                n_clears++;
            end
            OP_READ:
            begin
                if (w.cell_index < CELL_COUNT)
                    rd_word = screen_copy[w.cell_index];
                else
                    n_reads_oob++;
            end
            default: ;
        endcase
        r.cursor_row    = ROW_W'(cur_row);
        r.cursor_column = COL_W'(cur_col);
        r.cell_value    = rd_word;
    endtask

    // result check first, then prediction for the word taken at this edge
    always @(posedge clk)
    begin : monitor
        tcw_out_t      got;
        tcw_out_t      want;
        tcw_out_t      predicted;
        typed_result_t t;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (pop && !empty)
            begin
                moved = 1'b1;
                got = result;
                if (awaited_q.size() == 0)
                    report_mismatch("unexpected word, cell", 0, got.cell_value);
                else
                begin
                    want = awaited_q.pop_front();
                    if (got.cursor_row != want.cursor_row)
                        report_mismatch("cursor_row", want.cursor_row, got.cursor_row);
                    if (got.cursor_column != want.cursor_column)
                        report_mismatch("cursor_column", want.cursor_column,
                                        got.cursor_column);
                    if (got.cell_value != want.cell_value)
                        report_mismatch("cell_value", want.cell_value, got.cell_value);
                end
            end
            if (push && !full)
            begin
                moved = 1'b1;
                console_step(item, predicted);
                t = '0;
                if (typed_q.size() != 0)
                    t = typed_q.pop_front();
                awaited_q.push_back(t.typed ? t.value : predicted);
                n_words++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_wanted && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input tcw_in_t w, input logic typed, input tcw_out_t value);
        typed_q.push_back('{typed, value});
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
    endtask

    function automatic tcw_in_t pick_word();
        int r;
        tcw_in_t w;
        w.character  = CHAR_W'($urandom);
        w.cell_index = IDX_W'($urandom);
        r = $urandom_range(99);
        if (r < 70)
        begin
            w.operation = OP_PUT;
            r = $urandom_range(99);
            if (r < 68)
                w.character = CHAR_W'($urandom_range(CHAR_PRINT_HI, CHAR_PRINT_LO));
            else if (r < 76)
                w.character = CHAR_LF;
            else if (r < 81)
                w.character = CHAR_CR;
            else if (r < 89)
                w.character = CHAR_TAB;
        end
        else if (r < 71)
            w.operation = OP_CLEAR;
        else if (r < 96)
        begin
            w.operation = OP_READ;
            r = $urandom_range(99);
            // half of the reads target cells up to the cursor, where text has landed
            if (r < 50)
                w.cell_index = IDX_W'($urandom_range(cur_row * COLUMNS + cur_col));
            else if (r < 90)
                w.cell_index = IDX_W'($urandom_range(CELL_COUNT - 1));
        end
        else
            w.operation = OP_UNUSED;
        return w;
    endfunction

    task automatic random_phase(input int words);
        repeat (words)
            send_word(pick_word(), 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (awaited_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_text_attribute(input logic [ATTR_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TEXT_ATTRIBUTE, 2'b00};
        pwdata  <= {24'($urandom), v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        attr_now = v;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[ATTR_W-1:0] != v)
            report_mismatch("text_attribute readback", v, prdata[ATTR_W-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        tcw_in_t  w;
        tcw_out_t v;
        foreach (screen_copy[i])
            screen_copy[i] = RESET_CELL;
        attr_now  = RESET_ATTR;
        cur_row   = 0;
        cur_col   = 0;
        send_idle = 10;
        recv_idle = 10;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (STEPS[s])
        begin
            w.operation     = STEPS[s].op;
            w.character     = STEPS[s].ch;
            w.cell_index    = STEPS[s].idx;
            v.cursor_row    = STEPS[s].row;
            v.cursor_column = STEPS[s].col;
            v.cell_value    = STEPS[s].cell_exp;
            repeat (STEPS[s].reps)
                send_word(w, STEPS[s].typed, v);
        end
        drain();

        set_text_attribute(8'hFF);
        send_idle = 32;
        recv_idle = 87;
        random_phase(PHASE_WORDS);
        drain();

        set_text_attribute(8'h00);
        send_idle = 87;
        recv_idle = 32;
        random_phase(PHASE_WORDS);
        drain();

        set_text_attribute(ATTR_W'($urandom_range(254, 1)));
        send_idle   = 0;
        recv_idle   = 0;
        hold_wanted = 1'b1;
        random_phase(PHASE_WORDS);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d words: %0d scrolls, %0d clears, %0d reads past the screen",
                 n_words, n_scrolls, n_clears, n_reads_oob);
        $display("attribute run at reset, 0xff, 0x00 and one random value; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
dv/text_console_writer_test.sv
